### hw/rtl/cfv_pkg.sv
// shared types, constants and register codes for the command frame validator
package cfv_pkg;

    localparam int unsigned MAX_PAYLOAD     = 255;
    localparam int unsigned HEADER_BYTES    = 5;
    localparam int unsigned MIN_FRAME_BYTES = 6;
    localparam int unsigned POS_W           = 9;
    localparam int unsigned POSITION_TOP    = (1 << POS_W) - 1;
    localparam int unsigned CFG_DATA_W      = 16;
    localparam int unsigned CFG_INDEX_W     = 2;

    localparam logic [15:0] PREAMBLE_RESET   = 16'h0000;
    localparam logic [7:0]  LEN_MIN_RESET    = 8'd3;
    localparam logic [7:0]  CMD_LIMIT_RESET  = 8'd8;
    localparam logic [7:0]  DOWNSTREAM_RESET = 8'd0;

    localparam logic [15:0] HEAD_HI_MASK = 16'hff00;
    localparam logic [15:0] HEAD_LO_MASK = 16'h00ff;

    typedef logic [POS_W-1:0] cfv_pos_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PREAMBLE   = 2'd0,
        REG_LEN_MIN    = 2'd1,
        REG_CMD_LIMIT  = 2'd2,
        REG_DOWNSTREAM = 2'd3
    } cfv_reg_idx_t;

    typedef struct packed {
        logic [15:0] expected_preamble;
        logic [7:0]  length_minimum;
        logic [7:0]  command_limit;
        logic [7:0]  downstream_code;
    } cfv_cfg_t;

    typedef struct packed {
        logic        frame_ok;
        logic [15:0] head_value;
        logic [7:0]  length_value;
        logic [7:0]  command_value;
        logic [7:0]  subcommand_value;
        logic [7:0]  payload_count;
    } cfv_result_t;

endpackage

### hw/rtl/command_frame_validator.sv
// top level of the command frame validator
//
// Frame bytes enter on the input channel (in_valid, in_stall) with data_byte,
// frame_end marks the check byte that closes a frame. Each frame gives one
// result beat on the output channel (out_valid, out_stall): frame_ok, the
// captured header fields and the payload count.
// A byte is taken in every cycle with in_valid high and in_stall low; there
// is no idle time between frames. The final byte's result is registered into
// the output register, or parked in the skid entry while the output is held.
// The result register is backed by one skid entry. While the receiver
// stalls, the block keeps taking bytes; in_stall rises only when a second
// result is waiting in the skid entry, and falls the cycle after the output
// register drains.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at the
// next edge; the user must write only while no frame is in flight, which the
// block does not enforce. Reset clears the frame state and both result entries
// and loads register defaults; the first byte after reset starts a new frame.
module command_frame_validator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [cfv_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cfv_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       data_byte,
    input  logic                             frame_end,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             frame_ok,
    output logic [15:0]                      head_value,
    output logic [7:0]                       length_value,
    output logic [7:0]                       command_value,
    output logic [7:0]                       subcommand_value,
    output logic [7:0]                       payload_count
);

    cfv_pkg::cfv_cfg_t    cfg;
    cfv_pkg::cfv_result_t result;
    cfv_pkg::cfv_result_t out_reg,  out_next;
    cfv_pkg::cfv_result_t skid_reg, skid_next;
    logic                 out_valid_reg,  out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic                 beat;
    logic                 res_valid;
    logic                 out_pop;

    cfv_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cfv_frame_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .cfg       (cfg),
        .result    (result)
    );

    assign in_stall  = skid_valid_reg;
    assign beat      = in_valid && !in_stall;
    assign res_valid = beat && frame_end;
    assign out_pop   = out_valid_reg && !out_stall;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = result;
                skid_valid_next = res_valid;
            end
            else
            begin
                out_next       = result;
                out_valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            // output held by the receiver, park the new result
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid        = out_valid_reg;
    assign frame_ok         = out_reg.frame_ok;
    assign head_value       = out_reg.head_value;
    assign length_value     = out_reg.length_value;
    assign command_value    = out_reg.command_value;
    assign subcommand_value = out_reg.subcommand_value;
    assign payload_count    = out_reg.payload_count;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while output is empty");

    a_park_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid_reg && out_stall |=> skid_valid_reg)
        else $error("result lost while output stalled");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_pop && !skid_valid_reg && !res_valid |=> !out_valid_reg)
        else $error("output beat repeated after it was taken");

endmodule

### hw/rtl/cfv_cfg_regs.sv
// configuration register bank for the command frame validator
module cfv_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [cfv_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cfv_pkg::CFG_DATA_W-1:0]     cfg_data,
    output cfv_pkg::cfv_cfg_t                  cfg
);

    cfv_pkg::cfv_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_preamble <= cfv_pkg::PREAMBLE_RESET;
            cfg_reg.length_minimum    <= cfv_pkg::LEN_MIN_RESET;
            cfg_reg.command_limit     <= cfv_pkg::CMD_LIMIT_RESET;
            cfg_reg.downstream_code   <= cfv_pkg::DOWNSTREAM_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                cfv_pkg::REG_PREAMBLE:   cfg_reg.expected_preamble <= cfg_data;
                cfv_pkg::REG_LEN_MIN:    cfg_reg.length_minimum    <= cfg_data[7:0];
                cfv_pkg::REG_CMD_LIMIT:  cfg_reg.command_limit     <= cfg_data[7:0];
                cfv_pkg::REG_DOWNSTREAM: cfg_reg.downstream_code   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/cfv_frame_track.sv
// per-frame byte tracking, header capture and end-of-frame checks
module cfv_frame_track (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  beat,
    input  logic [7:0]            data_byte,
    input  logic                  frame_end,
    input  cfv_pkg::cfv_cfg_t     cfg,
    output cfv_pkg::cfv_result_t  result
);

    cfv_pkg::cfv_pos_t pos_reg,     pos_next;
    logic [7:0]        sum_reg,     sum_next;
    logic [15:0]       head_reg,    head_next;
    logic [7:0]        len_reg,     len_next;
    logic [7:0]        cmd_reg,     cmd_next;
    logic [7:0]        sub_reg,     sub_next;

    cfv_pkg::cfv_pos_t payload_wide;
    logic [7:0]        payload;
    logic              short_frame;
    logic              long_frame;
    logic [8:0]        len_expect;
    logic [7:0]        byte_total;
    logic              ok;

    // byte accumulation for non-final bytes, clear after the final one
    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        head_next = head_reg;
        len_next  = len_reg;
        cmd_next  = cmd_reg;
        sub_next  = sub_reg;
        if (beat)
        begin
            if (frame_end)
            begin
                pos_next  = '0;
                sum_next  = '0;
                head_next = '0;
                len_next  = '0;
                cmd_next  = '0;
                sub_next  = '0;
            end
            else
            begin
                case (pos_reg)
                    cfv_pkg::cfv_pos_t'(0): head_next = {data_byte, 8'h00}
                                                      & cfv_pkg::HEAD_HI_MASK;
                    cfv_pkg::cfv_pos_t'(1): head_next = (head_reg & cfv_pkg::HEAD_HI_MASK)
                                      | ({8'h00, data_byte} & cfv_pkg::HEAD_LO_MASK);
                    cfv_pkg::cfv_pos_t'(2): len_next  = data_byte;
                    cfv_pkg::cfv_pos_t'(3): cmd_next  = data_byte;
                    cfv_pkg::cfv_pos_t'(4): sub_next  = data_byte;
                    default: ;
                endcase
                sum_next = sum_reg + data_byte;
                if (pos_reg != cfv_pkg::cfv_pos_t'(cfv_pkg::POSITION_TOP))
                begin
                    pos_next = pos_reg + cfv_pkg::cfv_pos_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            head_reg <= '0;
            len_reg  <= '0;
            cmd_reg  <= '0;
            sub_reg  <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            head_reg <= head_next;
            len_reg  <= len_next;
            cmd_reg  <= cmd_next;
            sub_reg  <= sub_next;
        end
    end

    // checks on the final byte, against the bytes stored so far
    always_comb
    begin
        short_frame  = pos_reg < cfv_pkg::cfv_pos_t'(cfv_pkg::MIN_FRAME_BYTES - 1);
        payload_wide = short_frame ? '0
                     : pos_reg - cfv_pkg::cfv_pos_t'(cfv_pkg::HEADER_BYTES);
        long_frame   = payload_wide > cfv_pkg::cfv_pos_t'(cfv_pkg::MAX_PAYLOAD);
        payload      = long_frame ? 8'(cfv_pkg::MAX_PAYLOAD) : payload_wide[7:0];
        len_expect   = {1'b0, payload} + {1'b0, cfg.length_minimum};
        // sum of all bytes including the check byte wraps to zero when valid
        byte_total   = sum_reg + data_byte;
        ok = !short_frame && !long_frame
           && (head_reg == cfg.expected_preamble)
           && (len_reg >= cfg.length_minimum)
           && ({1'b0, len_reg} == len_expect)
           && (cmd_reg < cfg.command_limit)
           && (sub_reg == cfg.downstream_code)
           && (byte_total == 8'h00);

        result.frame_ok         = ok;
        result.head_value       = head_reg;
        result.length_value     = len_reg;
        result.command_value    = cmd_reg;
        result.subcommand_value = sub_reg;
        result.payload_count    = payload;
    end

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        beat && frame_end |=> pos_reg == '0 && sum_reg == '0)
        else $error("frame state not cleared after final byte");

    a_pos_advances: assert property (@(posedge clk) disable iff (!rst_n)
        beat && !frame_end && pos_reg != cfv_pkg::cfv_pos_t'(cfv_pkg::POSITION_TOP)
        |=> pos_reg == $past(pos_reg) + cfv_pkg::cfv_pos_t'(1))
        else $error("byte position did not advance");

    a_pos_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !beat |=> $stable(pos_reg) && $stable(sum_reg))
        else $error("frame state moved without a beat");

endmodule
